// ===== hdl/cge_pkg.sv =====
package cge_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_W = 48;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned MUL_W = 34;

	localparam int unsigned MAX_PUSH_STEPS_DEF = 64;
	localparam int unsigned FRAC_BITS_DEF = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd3;

	localparam logic [30:0] RADIUS_RESET = 31'd17039360;

	// Reciprocal of ten for an exact 32-bit unsigned divide: q = (v * R) >> 35.
	localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
	localparam int unsigned DIV10_SHIFT = 35;

	typedef struct packed {
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] vel_x;
		logic signed [WORD_W-1:0] vel_y;
		logic last_item;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] new_pos_x;
		logic signed [WORD_W-1:0] new_pos_y;
		logic signed [WORD_W-1:0] new_vel_x;
		logic signed [WORD_W-1:0] new_vel_y;
		logic landed;
		logic push_overflow;
		logic last_out;
	} result_t;

endpackage

// ===== hdl/central_gravity_euler_step.sv =====
// Without contact, an item passes through a square root, two divisions and the multiply
// and update steps before done. Zero distance skips the divisions, and a capped quotient
// ends a division after its first step. Contact adds outward push steps, up to
// MAX_PUSH_STEPS steps. One item at a time: busy stays high until done, so a new start is
// taken only once the block is idle again. The result comes with a one-cycle done strobe
// and cannot be stalled. arst_n clears the sequencer and loads register reset values.
module central_gravity_euler_step #(
	parameter int unsigned MAX_PUSH_STEPS = cge_pkg::MAX_PUSH_STEPS_DEF,
	parameter int unsigned FRAC_BITS = cge_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cge_pkg::item_t item,
	output logic busy,
	output logic done,
	output cge_pkg::result_t result,
	input  logic cfg_we,
	input  logic [cge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cge_pkg::CFG_W-1:0] cfg_data
);

	localparam int unsigned NUM_W = 81 + 2 * FRAC_BITS;
	localparam int unsigned SW = $clog2(MAX_PUSH_STEPS + 1);
	localparam int unsigned MW = cge_pkg::MUL_W;

	typedef enum logic [26:0] {
		S_IDLE = 27'd1 << 0,
		S_D2A  = 27'd1 << 1,
		S_D2B  = 27'd1 << 2,
		S_D2C  = 27'd1 << 3,
		S_SQRT = 27'd1 << 4,
		S_DEN0 = 27'd1 << 5,
		S_DEN1 = 27'd1 << 6,
		S_DEN2 = 27'd1 << 7,
		S_NX0  = 27'd1 << 8,
		S_NX1  = 27'd1 << 9,
		S_NX2  = 27'd1 << 10,
		S_DIVX = 27'd1 << 11,
		S_NY0  = 27'd1 << 12,
		S_NY1  = 27'd1 << 13,
		S_NY2  = 27'd1 << 14,
		S_DIVY = 27'd1 << 15,
		S_VEL  = 27'd1 << 16,
		S_POS  = 27'd1 << 17,
		S_IN0  = 27'd1 << 18,
		S_IN1  = 27'd1 << 19,
		S_IN2  = 27'd1 << 20,
		S_IN3  = 27'd1 << 21,
		S_UX   = 27'd1 << 22,
		S_UY   = 27'd1 << 23,
		S_UY2  = 27'd1 << 24,
		S_PUSH = 27'd1 << 25,
		S_DONE = 27'd1 << 26
	} state_t;

	// Saturate a wide signed sum to the 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	state_t state_q;

	logic signed [31:0] cx_q, cy_q;
	logic [47:0] g_q;
	logic [30:0] rad_q;

	logic signed [31:0] px_q, py_q, vx_q, vy_q, ux_q, uy_q;
	logic last_q;
	logic signed [32:0] dx_q, dy_q;
	logic [65:0] d2_q;
	logic [33:0] r_q;
	logic [99:0] den_q;
	logic [80:0] acc_q;
	logic [61:0] rad2_q;
	logic signed [34:0] ax_q, ay_q;
	logic [SW-1:0] steps_q;
	logic pushing_q, landed_q, ovf_q;
	logic done_q;
	cge_pkg::result_t result_q;

	logic [MW-1:0] mul_a, mul_b;
	logic [2*MW-1:0] mul_p;
	logic [32:0] mag_dx, mag_dy;
	logic [31:0] mag_vx, mag_vy;
	logic [65:0] d2_sum;
	logic [80:0] gd_sum;
	logic [NUM_W-1:0] div_num;
	logic sqrt_start, sqrt_done, div_start, div_done;
	logic [32:0] sqrt_root;
	logic [33:0] div_quot;
	logic [28:0] tenth;
	logic in_now;

	assign mag_dx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign mag_dy = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign mag_vx = vx_q[31] ? 32'(-vx_q) : 32'(vx_q);
	assign mag_vy = vy_q[31] ? 32'(-vy_q) : 32'(vy_q);

	// Sums that close the two-pass products.
	assign d2_sum = 66'(acc_q[64:0]) + 66'(mul_p[64:0]);
	assign gd_sum = acc_q + {mul_p[56:0], 24'b0};
	assign div_num = {gd_sum, {(2 * FRAC_BITS){1'b0}}};
	assign in_now = (d2_sum <= 66'(rad2_q));
	assign tenth = mul_p[63:35];

	assign sqrt_start = (state_q == S_D2C);
	assign div_start = (state_q == S_NX2) || (state_q == S_NY2);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_D2A, S_IN1: begin
				mul_a = MW'(mag_dx);
				mul_b = MW'(mag_dx);
			end
			S_D2B, S_IN2: begin
				mul_a = MW'(mag_dy);
				mul_b = MW'(mag_dy);
			end
			S_DEN0: begin
				mul_a = MW'(d2_q[32:0]);
				mul_b = r_q;
			end
			S_DEN1: begin
				mul_a = MW'(d2_q[65:33]);
				mul_b = r_q;
			end
			S_NX0: begin
				mul_a = MW'(g_q[23:0]);
				mul_b = MW'(mag_dx);
			end
			S_NX1: begin
				mul_a = MW'(g_q[47:24]);
				mul_b = MW'(mag_dx);
			end
			S_NY0: begin
				mul_a = MW'(g_q[23:0]);
				mul_b = MW'(mag_dy);
			end
			S_NY1: begin
				mul_a = MW'(g_q[47:24]);
				mul_b = MW'(mag_dy);
			end
			S_VEL: begin
				mul_a = MW'(rad_q);
				mul_b = MW'(rad_q);
			end
			S_UX: begin
				mul_a = MW'(mag_vx);
				mul_b = MW'(cge_pkg::DIV10_RECIP);
			end
			S_UY: begin
				mul_a = MW'(mag_vy);
				mul_b = MW'(cge_pkg::DIV10_RECIP);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cge_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	cge_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (d2_sum),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	cge_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			g_q <= '0;
			rad_q <= cge_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cge_pkg::CFG_CENTER_X: cx_q <= cfg_data[31:0];
				cge_pkg::CFG_CENTER_Y: cy_q <= cfg_data[31:0];
				cge_pkg::CFG_GRAVITY:  g_q <= cfg_data[47:0];
				cge_pkg::CFG_RADIUS:   rad_q <= cfg_data[30:0];
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			pushing_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_D2A;
				S_D2A: state_q <= S_D2B;
				S_D2B: state_q <= S_D2C;
				S_D2C: state_q <= S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= (sqrt_root == 33'd0) ? S_VEL : S_DEN0;
					end
				end
				S_DEN0: state_q <= S_DEN1;
				S_DEN1: state_q <= S_DEN2;
				S_DEN2: state_q <= S_NX0;
				S_NX0: state_q <= S_NX1;
				S_NX1: state_q <= S_NX2;
				S_NX2: state_q <= S_DIVX;
				S_DIVX: if (div_done) state_q <= S_NY0;
				S_NY0: state_q <= S_NY1;
				S_NY1: state_q <= S_NY2;
				S_NY2: state_q <= S_DIVY;
				S_DIVY: if (div_done) state_q <= S_VEL;
				S_VEL: state_q <= S_POS;
				S_POS: state_q <= S_IN0;
				S_IN0: state_q <= S_IN1;
				S_IN1: state_q <= S_IN2;
				S_IN2: state_q <= S_IN3;
				S_IN3: begin
					if (!pushing_q) begin
						state_q <= in_now ? S_UX : S_DONE;
					end else if (in_now && steps_q < SW'(MAX_PUSH_STEPS)) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_UX: state_q <= S_UY;
				S_UY: state_q <= S_UY2;
				S_UY2: begin
					pushing_q <= 1'b1;
					state_q <= S_PUSH;
				end
				S_PUSH: state_q <= S_IN0;
				S_DONE: begin
					done_q <= 1'b1;
					pushing_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					px_q <= item.pos_x;
					py_q <= item.pos_y;
					vx_q <= item.vel_x;
					vy_q <= item.vel_y;
					last_q <= item.last_item;
					dx_q <= 33'(cx_q) - 33'(item.pos_x);
					dy_q <= 33'(cy_q) - 33'(item.pos_y);
					ax_q <= '0;
					ay_q <= '0;
					landed_q <= 1'b0;
					ovf_q <= 1'b0;
					steps_q <= '0;
				end
			end
			S_D2B, S_DEN1, S_NX1, S_NY1, S_IN2: acc_q <= 81'(mul_p);
			S_D2C: d2_q <= d2_sum;
			S_SQRT: if (sqrt_done) r_q <= {1'b0, sqrt_root};
			S_DEN2: den_q <= 100'(acc_q[66:0]) + {mul_p[66:0], 33'b0};
			S_DIVX: if (div_done) ax_q <= dx_q[32] ? -35'(div_quot) : 35'(div_quot);
			S_DIVY: if (div_done) ay_q <= dy_q[32] ? -35'(div_quot) : 35'(div_quot);
			S_VEL: begin
				vx_q <= sat32(36'(vx_q) + 36'(ax_q));
				vy_q <= sat32(36'(vy_q) + 36'(ay_q));
			end
			S_POS: begin
				rad2_q <= mul_p[61:0];
				px_q <= sat32(36'(px_q) + 36'(vx_q));
				py_q <= sat32(36'(py_q) + 36'(vy_q));
			end
			S_IN0: begin
				dx_q <= 33'(cx_q) - 33'(px_q);
				dy_q <= 33'(cy_q) - 33'(py_q);
			end
			S_IN3: begin
				if (pushing_q && !(in_now && steps_q < SW'(MAX_PUSH_STEPS))) begin
					ovf_q <= in_now;
					landed_q <= 1'b1;
					vx_q <= '0;
					vy_q <= '0;
				end
			end
			// Push velocity is minus a tenth of the velocity, truncated toward zero.
			S_UY: ux_q <= vx_q[31] ? 32'(tenth) : -32'(tenth);
			S_UY2: uy_q <= vy_q[31] ? 32'(tenth) : -32'(tenth);
			S_PUSH: begin
				px_q <= sat32(36'(px_q) + 36'(ux_q));
				py_q <= sat32(36'(py_q) + 36'(uy_q));
				steps_q <= steps_q + SW'(1);
			end
			S_DONE: begin
				result_q.new_pos_x <= px_q;
				result_q.new_pos_y <= py_q;
				result_q.new_vel_x <= vx_q;
				result_q.new_vel_y <= vy_q;
				result_q.landed <= landed_q;
				result_q.push_overflow <= ovf_q;
				result_q.last_out <= last_q;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule

// ===== hdl/cge_mul.sv =====
// Shared registered multiplier; the product appears in the cycle after the operands.
module cge_mul (
	input  logic clk,
	input  logic [cge_pkg::MUL_W-1:0] a,
	input  logic [cge_pkg::MUL_W-1:0] b,
	output logic [2*cge_pkg::MUL_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== hdl/cge_sqrt.sv =====
// Bit-pair integer square root of a 66-bit value, one result bit per cycle.
module cge_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [65:0] n,
	output logic done,
	output logic [32:0] root
);

	logic [65:0] n_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic ge;

	// Bring down the next bit pair and try the next root bit.
	assign rem_sh = {rem_q[33:0], n_q[65:64]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[63:0], 2'b00};
			rem_q <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[31:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/cge_div.sv =====
// Restoring divider that yields the quotient capped at 2^33, one bit per cycle.
module cge_div #(
	parameter int unsigned NUM_W = 113
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [NUM_W-1:0] num,
	input  logic [99:0] den,
	output logic done,
	output logic [33:0] quot
);

	localparam int unsigned DEN_SH_W = 134;
	localparam int unsigned CW = (NUM_W > DEN_SH_W) ? NUM_W : DEN_SH_W;

	logic [CW-1:0] rem_q;
	logic [CW-1:0] dsh_q;
	logic [32:0] q_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic cap_q;
	logic ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (busy_q) begin
				// The first step only checks for a quotient at or above the cap.
				if (cnt_q == 6'd0 || (cnt_q == 6'd33 && ge)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CW'(num);
			dsh_q <= CW'({den, 33'b0});
			q_q <= '0;
			cap_q <= 1'b0;
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (cnt_q == 6'd33) begin
				cap_q <= ge;
			end else begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				q_q <= {q_q[31:0], ge};
			end
		end
	end

	assign done = done_q;
	assign quot = cap_q ? {1'b1, 33'b0} : {1'b0, q_q};

endmodule

// ===== hdl/cge_checker.sv =====
// Port-level checks on the command handshake and result consistency.
module cge_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input cge_pkg::result_t result
);

	// An accepted command makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted command did not raise busy");

	// A result strobe comes when the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// A result lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	// Overflow only comes with a landing.
	a_ovf_landed: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.push_overflow |-> result.landed)
		else $error("push overflow without landing");

	// A landed projectile has zero velocity.
	a_landed_still: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.landed |-> result.new_vel_x == 0 && result.new_vel_y == 0)
		else $error("landed with nonzero velocity");

endmodule

bind central_gravity_euler_step cge_checker u_cge_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== verif/central_gravity_euler_step_test.sv =====
`timescale 1ns / 1ps

module central_gravity_euler_step_test;

	localparam int PUSH_LIMIT = cge_pkg::MAX_PUSH_STEPS_DEF;
	localparam int FRAC = cge_pkg::FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 800;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// Scoreboard: holds the register copy, predicts each step and checks results in order.
	class gravity_scoreboard;
		longint ctr_x, ctr_y;
		bit [63:0] strength, radius;
		cge_pkg::result_t pending[$];
		int mismatches, results_seen, landings, overflows;

		function new();
			ctr_x = 0;
			ctr_y = 0;
			strength = 0;
			radius = cge_pkg::RADIUS_RESET;
		endfunction

		function void write_reg(logic [cge_pkg::CFG_IDX_W-1:0] idx,
				logic [cge_pkg::CFG_W-1:0] data);
			case (idx)
				cge_pkg::CFG_CENTER_X: ctr_x = longint'($signed(data[31:0]));
				cge_pkg::CFG_CENTER_Y: ctr_y = longint'($signed(data[31:0]));
				cge_pkg::CFG_GRAVITY: strength = data;
				cge_pkg::CFG_RADIUS: radius = data[30:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] magnitude(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint clamp32(longint v);
			if (v > S32_MAX) return S32_MAX;
			if (v < S32_MIN) return S32_MIN;
			return v;
		endfunction

		function bit [127:0] dist_sq(longint dx, longint dy);
			bit [127:0] mx, my;
			mx = magnitude(dx);
			my = magnitude(dy);
			return mx * mx + my * my;
		endfunction

		function bit [63:0] int_sqrt(bit [127:0] n);
			bit [127:0] res, cand;
			res = 0;
			for (int b = 33; b >= 0; b--) begin
				cand = res | (128'd1 << b);
				if (cand * cand <= n) res = cand;
			end
			return res[63:0];
		endfunction

		// Acceleration component, magnitude capped before it is added.
		function longint pull(longint d, bit [127:0] d2, bit [63:0] r);
			bit [127:0] num, den, q, rr;
			bit [63:0] m;
			if (r == 0) return 0;
			num = strength;
			num = num * magnitude(d);
			num = num << (2 * FRAC);
			rr = r;
			den = d2 * rr;
			q = num / den;
			m = (q > (128'd1 << 33)) ? (64'd1 << 33) : q[63:0];
			return d < 0 ? -longint'(m) : longint'(m);
		endfunction

		function bit in_contact(longint px, longint py);
			bit [127:0] rr;
			rr = radius;
			return dist_sq(ctr_x - px, ctr_y - py) <= rr * rr;
		endfunction

		function cge_pkg::result_t euler_step(cge_pkg::item_t it);
			longint px, py, vx, vy, dx, dy, ux, uy;
			bit [127:0] d2;
			bit [63:0] r;
			int n;
			bit still_in;
			cge_pkg::result_t o;
			px = it.pos_x;
			py = it.pos_y;
			vx = it.vel_x;
			vy = it.vel_y;
			dx = ctr_x - px;
			dy = ctr_y - py;
			d2 = dist_sq(dx, dy);
			r = int_sqrt(d2);
			vx = clamp32(vx + pull(dx, d2, r));
			vy = clamp32(vy + pull(dy, d2, r));
			px = clamp32(px + vx);
			py = clamp32(py + vy);
			o.landed = 0;
			o.push_overflow = 0;
			// On contact, back out along a tenth of the reversed velocity.
			if (in_contact(px, py)) begin
				ux = -(vx / 10);
				uy = -(vy / 10);
				n = 0;
				still_in = 1;
				while (still_in && n < PUSH_LIMIT) begin
					px = clamp32(px + ux);
					py = clamp32(py + uy);
					n++;
					still_in = in_contact(px, py);
				end
				o.push_overflow = still_in;
				vx = 0;
				vy = 0;
				o.landed = 1;
			end
			o.new_pos_x = px[31:0];
			o.new_pos_y = py[31:0];
			o.new_vel_x = vx[31:0];
			o.new_vel_y = vy[31:0];
			o.last_out = it.last_item;
			return o;
		endfunction

		function void note_item(cge_pkg::item_t it);
			pending.push_back(euler_step(it));
		endfunction

		function void check_result(cge_pkg::result_t got);
			cge_pkg::result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.landed === 1'b1) landings++;
			if (got.push_overflow === 1'b1) overflows++;
			if (got.new_pos_x !== want.new_pos_x || got.new_pos_y !== want.new_pos_y ||
					got.new_vel_x !== want.new_vel_x || got.new_vel_y !== want.new_vel_y ||
					got.landed !== want.landed || got.push_overflow !== want.push_overflow ||
					got.last_out !== want.last_out) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result %0d pos %h %h vel %h %h land %b ovf %b last %b",
						results_seen, got.new_pos_x, got.new_pos_y, got.new_vel_x,
						got.new_vel_y, got.landed, got.push_overflow, got.last_out);
					$display("       expected pos %h %h vel %h %h land %b ovf %b last %b",
						want.new_pos_x, want.new_pos_y, want.new_vel_x, want.new_vel_y,
						want.landed, want.push_overflow, want.last_out);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	cge_pkg::item_t item;
	logic busy;
	logic done;
	cge_pkg::result_t result;
	logic cfg_we;
	logic [cge_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cge_pkg::CFG_W-1:0] cfg_data;

	gravity_scoreboard sb;
	int stall_count;
	int items_sent;

	central_gravity_euler_step DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
		end
		if (stall_count >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	function longint clip32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// Offer one item, wait for its transfer, then idle for a random gap that may be empty.
	task automatic send_item(cge_pkg::item_t it);
		int g;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note_item(it);
		items_sent++;
		g = pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Let the block drain before touching any register.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drive one register write; the caller drops the write enable after the last one.
	task automatic write_reg(logic [cge_pkg::CFG_IDX_W-1:0] idx,
			logic [cge_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Upper bits of the center and radius writes carry junk that the block must drop.
	task automatic setup(longint cx, longint cy, logic [47:0] g, logic [30:0] rad);
		write_reg(cge_pkg::CFG_CENTER_X, {16'($urandom), 32'(cx)});
		write_reg(cge_pkg::CFG_CENTER_Y, {16'($urandom), 32'(cy)});
		write_reg(cge_pkg::CFG_GRAVITY, g);
		write_reg(cge_pkg::CFG_RADIUS, {17'($urandom), rad});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function cge_pkg::item_t make_item(longint px, longint py, longint vx, longint vy);
		cge_pkg::item_t it;
		it.pos_x = px[31:0];
		it.pos_y = py[31:0];
		it.vel_x = vx[31:0];
		it.vel_y = vy[31:0];
		it.last_item = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function longint rand_vel();
		longint m;
		m = $urandom_range(0, 1 << $urandom_range(0, 24));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function longint rand_off();
		longint m, rad;
		rad = sb.radius;
		if (rad == 0) rad = 64'd1 << 20;
		m = longint'($urandom_range(0, 3000)) * rad / 1000;
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// Mostly shots near the contact circle, the rest unconstrained words.
	task automatic random_items(int count);
		cge_pkg::item_t it;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				it = make_item(clip32(sb.ctr_x + rand_off()), clip32(sb.ctr_y + rand_off()),
					rand_vel(), rand_vel());
			end else begin
				it = make_item(longint'($signed($urandom)), longint'($signed($urandom)),
					longint'($signed($urandom)), longint'($signed($urandom)));
			end
			send_item(it);
		end
	endtask

	initial begin
		longint rad;
		sb = new();
		stall_count = 0;
		items_sent = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= cge_pkg::CFG_CENTER_X;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, field extremes, zero distance, boundary contact.
		setup(0, 0, 48'd0, cge_pkg::RADIUS_RESET);
		rad = cge_pkg::RADIUS_RESET;
		send_item(make_item(S32_MAX, S32_MAX, S32_MAX, S32_MAX));
		send_item(make_item(S32_MIN, S32_MIN, S32_MIN, S32_MIN));
		send_item(make_item(S32_MAX, S32_MIN, S32_MIN, S32_MAX));
		send_item(make_item(0, 0, 0, 0));
		send_item(make_item(0, 0, 5, -7));
		send_item(make_item(rad, 0, 0, 0));
		send_item(make_item(rad + 1, 0, 0, 0));
		send_item(make_item(0, -rad, 0, -1000));
		send_item(make_item(rad * 3, 0, -rad * 3, 0));
		drain();
		setup(64'sd1 << 24, -(64'sd1 << 24), 48'hFFFF_FFFF_FFFF, cge_pkg::RADIUS_RESET);
		send_item(make_item(64'sd1 << 24, -(64'sd1 << 24), 0, 0));
		send_item(make_item((64'sd1 << 24) + 1, -(64'sd1 << 24), 0, 0));
		send_item(make_item(S32_MAX, S32_MAX, 0, 0));
		send_item(make_item(S32_MIN, S32_MIN, S32_MAX, S32_MIN));
		send_item(make_item(0, 0, 0, 0));
		send_item(make_item((64'sd1 << 24) + rad * 2, -(64'sd1 << 24), 0, 1 << 18));
		drain();
		setup(S32_MAX, S32_MIN, 48'd0, 31'h7FFF_FFFF);
		send_item(make_item(0, 0, 0, 0));
		send_item(make_item(S32_MIN, S32_MAX, 0, 0));
		send_item(make_item(0, 0, 100, -100));
		drain();
		setup(S32_MIN, S32_MAX, 48'd1 << 40, 31'd0);
		send_item(make_item(S32_MIN, S32_MAX, 0, 0));
		send_item(make_item(S32_MIN + 1, S32_MAX, 0, 0));
		send_item(make_item(0, 0, 0, 0));
		drain();

		// Random phases over a spread of settings.
		setup(0, 0, 48'd1 << $urandom_range(28, 36), cge_pkg::RADIUS_RESET);
		random_items(260);
		drain();
		setup(longint'($signed($urandom)) >>> 4, longint'($signed($urandom)) >>> 4,
			48'd1 << $urandom_range(20, 44), 31'($urandom_range(1, 1 << 26)));
		random_items(260);
		drain();
		setup(S32_MAX, S32_MIN, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF);
		random_items(130);
		drain();
		setup(longint'($signed($urandom)), longint'($signed($urandom)), 48'd0, 31'd0);
		random_items(130);
		drain();
		setup(longint'($signed($urandom)) >>> 8, longint'($signed($urandom)) >>> 8,
			{16'($urandom), 32'($urandom)}, 31'($urandom));
		random_items(270);
		drain();

		$display("Covered %0d items over nine register settings: %0d landings, %0d push overflows.",
			items_sent, sb.landings, sb.overflows);
		$display("Results checked: %0d, mismatches: %0d, left over: %0d.",
			sb.results_seen, sb.mismatches, sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cge_pkg.sv
hdl/cge_mul.sv
hdl/cge_sqrt.sv
hdl/cge_div.sv
hdl/central_gravity_euler_step.sv
hdl/cge_checker.sv
verif/central_gravity_euler_step_test.sv
